// ----- sv/bks_pkg.sv -----
// shared types, command codes and size constants for the key stack
package bks_pkg;

    localparam int KEY_W           = 64;
    localparam int KEY_NUM_BYTES   = KEY_W / 8;
    localparam int CMD_W           = 3;
    localparam int DEPTH_OUT_W     = 4;
    localparam int STACK_DEPTH_DEF = 8;
    localparam int KEY_BYTES_DEF   = 8;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic                   ok;
        logic                   found;
        logic [KEY_W-1:0]       popped_key;
        logic [KEY_W-1:0]       top_key;
        logic [DEPTH_OUT_W-1:0] depth_now;
    } resp_t;

endpackage

// ----- sv/bks_keynorm.sv -----
// key normalizer: cuts a key at its first zero byte and checks its length
module bks_keynorm #(
    parameter int KEY_BYTES = bks_pkg::KEY_BYTES_DEF
) (
    input  logic [bks_pkg::KEY_W-1:0] key_in,
    output logic [bks_pkg::KEY_W-1:0] key_norm,
    output logic                      key_ok
);

    logic [bks_pkg::KEY_NUM_BYTES:0] keep;
    logic                            alive;

    always_comb begin
        alive    = 1'b1;
        keep     = '0;
        key_norm = '0;
        for (int i = 0; i < bks_pkg::KEY_NUM_BYTES; i++) begin
            alive   = alive & (key_in[8*i +: 8] != 8'h00);
            keep[i] = alive;
            if (alive) begin
                key_norm[8*i +: 8] = key_in[8*i +: 8];
            end
        end
        // nonempty and no live byte at or beyond the allowed length
        key_ok = keep[0] & ~keep[KEY_BYTES];
    end

endmodule

// ----- sv/bks_mem.sv -----
// key store: one write port and one registered read port
module bks_mem #(
    parameter int DEPTH = bks_pkg::STACK_DEPTH_DEF,
    parameter int AW    = 3
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [bks_pkg::KEY_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [bks_pkg::KEY_W-1:0] rdata
);

    logic [bks_pkg::KEY_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/bounded_key_stack_with_search.sv -----
// top level of the bounded key stack with membership search
//
//  channel | ports                      | payload       | direction
//  --------+----------------------------+---------------+----------
//  request | s_valid s_ready s_req      | bks_pkg::req_t  | in
//  result  | m_valid m_ready m_resp     | bks_pkg::resp_t | out
//
// push, replace, clear and unknown commands go from accept straight to ST_DONE
// pop passes ST_POP when an entry is left below the new top (store read)
// search of a valid key in a nonempty stack walks ST_SRCH, stops at the first hit
// one request at a time; s_ready is high only while the sequencer is idle
// a result waiting on m_ready does not block the next accept, only its result
// aresetn (sync, active low) empties the stack; the store itself is never swept
module bounded_key_stack_with_search #(
    parameter int STACK_DEPTH = bks_pkg::STACK_DEPTH_DEF,
    parameter int KEY_BYTES   = bks_pkg::KEY_BYTES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  bks_pkg::req_t   s_req,
    output logic            m_valid,
    input  logic            m_ready,
    output bks_pkg::resp_t  m_resp
);

    // store address and fill count widths
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW = $clog2(STACK_DEPTH + 1);

    // one-hot sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SRCH = 4'b0010,
        ST_POP  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [FW-1:0]             fill_reg, fill_next;
    logic [FW-1:0]             idx_reg, idx_next;
    logic [bks_pkg::KEY_W-1:0] top_reg, top_next;
    logic [bks_pkg::KEY_W-1:0] key_reg, key_next;
    logic [bks_pkg::KEY_W-1:0] popped_reg, popped_next;
    logic                      ok_reg, ok_next;
    logic                      found_reg, found_next;
    logic                      m_valid_reg, m_valid_next;
    bks_pkg::resp_t            m_resp_reg, m_resp_next;

    // store port
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [bks_pkg::KEY_W-1:0] mem_wdata;
    logic [AW-1:0]             mem_raddr;
    logic [bks_pkg::KEY_W-1:0] mem_rdata;

    logic [bks_pkg::KEY_W-1:0] key_norm;
    logic                      key_ok;
    logic                      accept;
    logic                      not_full;
    logic                      not_empty;
    logic [FW-1:0]             fill_m1;
    logic [FW-1:0]             fill_m2;
    logic [FW-1:0]             idx_inc;
    logic [FW+3:0]             fill_wide;

    bks_keynorm #(
        .KEY_BYTES (KEY_BYTES)
    ) u_keynorm (
        .key_in   (s_req.key),
        .key_norm (key_norm),
        .key_ok   (key_ok)
    );

    bks_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid & s_ready;
    assign m_valid   = m_valid_reg;
    assign m_resp    = m_resp_reg;

    assign not_full  = (fill_reg < FW'(STACK_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign fill_m1   = fill_reg - FW'(1);
    assign fill_m2   = fill_reg - FW'(2);
    assign idx_inc   = idx_reg + FW'(1);
    // reported depth is the low bits of the fill count
    assign fill_wide = {4'b0000, fill_reg};

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        top_next     = top_reg;
        key_next     = key_reg;
        popped_next  = popped_reg;
        ok_next      = ok_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg;
        m_resp_next  = m_resp_reg;
        mem_we       = 1'b0;
        mem_waddr    = fill_reg[AW-1:0];
        mem_wdata    = key_norm;
        mem_raddr    = '0;

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    key_next    = key_norm;
                    ok_next     = 1'b0;
                    found_next  = 1'b0;
                    popped_next = '0;
                    idx_next    = '0;
                    state_next  = ST_DONE;
                    unique case (s_req.cmd)
                        bks_pkg::CMD_PUSH: begin
                            if (key_ok && not_full) begin
                                mem_we    = 1'b1;
                                mem_waddr = fill_reg[AW-1:0];
                                fill_next = fill_reg + FW'(1);
                                top_next  = key_norm;
                                ok_next   = 1'b1;
                            end
                        end
                        bks_pkg::CMD_POP: begin
                            if (not_empty) begin
                                // the cached top is the entry being removed
                                popped_next = top_reg;
                                fill_next   = fill_m1;
                                ok_next     = 1'b1;
                                if (fill_m1 != '0) begin
                                    // fetch the entry below to become the new top
                                    mem_raddr  = fill_m2[AW-1:0];
                                    state_next = ST_POP;
                                end else begin
                                    top_next = '0;
                                end
                            end
                        end
                        bks_pkg::CMD_REPLACE: begin
                            if (key_ok && not_empty) begin
                                mem_we    = 1'b1;
                                mem_waddr = fill_m1[AW-1:0];
                                top_next  = key_norm;
                                ok_next   = 1'b1;
                            end
                        end
                        bks_pkg::CMD_SEARCH: begin
                            ok_next = 1'b1;
                            if (key_ok && not_empty) begin
                                // walk from the bottom entry, one compare a cycle
                                mem_raddr  = '0;
                                state_next = ST_SRCH;
                            end
                        end
                        bks_pkg::CMD_CLEAR: begin
                            // the fill count alone marks entries live
                            fill_next = '0;
                            top_next  = '0;
                            ok_next   = 1'b1;
                        end
                        default: begin
                            // unknown command: no change, ok stays low
                        end
                    endcase
                end
            end
            ST_SRCH: begin
                // read data holds entry idx_reg; next read is issued at once
                mem_raddr = idx_inc[AW-1:0];
                idx_next  = idx_inc;
                if (mem_rdata == key_reg) begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end else if (idx_inc == fill_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_POP: begin
                top_next   = mem_rdata;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // load the output register once it is free or being emptied
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_resp_next.ok         = ok_reg;
                    m_resp_next.found      = found_reg;
                    m_resp_next.popped_key = popped_reg;
                    m_resp_next.top_key    = top_reg;
                    m_resp_next.depth_now  = fill_wide[3:0];
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            top_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            top_reg     <= top_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        popped_reg <= popped_next;
        ok_reg     <= ok_next;
        found_reg  <= found_next;
        m_resp_reg <= m_resp_next;
    end

endmodule

// ----- sv/bks_chk.sv -----
// port checker for the key stack and its bind to the top level
module bks_chk #(
    parameter int STACK_DEPTH = bks_pkg::STACK_DEPTH_DEF
) (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input bks_pkg::req_t  s_req,
    input logic           m_valid,
    input logic           m_ready,
    input bks_pkg::resp_t m_resp
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_resp))
        else $error("result changed while stalled");

    // one request in flight: ready drops after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // a failed command reports no pop and no hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_resp.ok |-> (m_resp.popped_key == '0) && !m_resp.found)
        else $error("failed command carries pop or hit");

    // an empty stack shows a zero top
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (STACK_DEPTH < 16) && (m_resp.depth_now == '0)
            |-> (m_resp.top_key == '0))
        else $error("empty stack with nonzero top");

endmodule

bind bounded_key_stack_with_search bks_chk #(
    .STACK_DEPTH (STACK_DEPTH)
) u_bks_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_req   (s_req),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_resp  (m_resp)
);
